// ===== src/mexp_pkg.sv =====
package mexp_pkg;

  // control for one step of the shared modular multiply unit
  typedef struct packed {
    logic mod_zero;  // modulus of zero: plain wrap-around arithmetic
    logic add_en;    // current multiplier bit is set
  } mexp_step_t;

endpackage

// ===== src/mexp_mulstep.sv =====
module mexp_mulstep #(
  parameter int MOD_WIDTH = 32
) (
  input  logic [MOD_WIDTH-1:0] rem_i,
  input  logic [MOD_WIDTH-1:0] addend_i,
  input  logic [MOD_WIDTH-1:0] modulus_i,
  input  mexp_pkg::mexp_step_t ctrl_i,
  output logic [MOD_WIDTH-1:0] rem_o
);
  import mexp_pkg::*;

  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH-1:0] rem_dbl;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;
  logic [MOD_WIDTH:0]   mod_ext;

  // interleaved multiply: rem = 2*rem + bit*addend, kept below a nonzero modulus
  always_comb begin
    mod_ext = {1'b0, modulus_i};
    dbl     = {rem_i, 1'b0};
    dbl_red = dbl;
    if (!ctrl_i.mod_zero && dbl >= mod_ext) begin
      dbl_red = dbl - mod_ext;
    end
    rem_dbl = dbl_red[MOD_WIDTH-1:0];
    sum     = {1'b0, rem_dbl};
    if (ctrl_i.add_en) begin
      sum = {1'b0, rem_dbl} + {1'b0, addend_i};
    end
    sum_red = sum;
    if (!ctrl_i.mod_zero && sum >= mod_ext) begin
      sum_red = sum - mod_ext;
    end
    rem_o = sum_red[MOD_WIDTH-1:0];
  end

endmodule

// ===== src/modular_exponentiation_top.sv =====
// modular exponentiation, right-to-left square and multiply
// command channel: base_value_i, exponent_i and modulus_i are taken at a
// rising edge with start_i high and busy_o low; busy_o stays high until the
// result is out, and no new transaction is taken meanwhile
// result channel: power_result_o is shown for exactly one cycle with valid_o
// high; the receiver cannot stall, so valid_o is never held (power_result_o keeps its value)
// all modular products go through one shared shift-add-reduce unit that
// handles one multiplier bit per cycle
// sequence: the base is first reduced, then each decision step either ends
// the run, or runs a multiply (for a set exponent bit) followed by a square,
// or a square alone; squares run for every exponent bit up to the highest
// set one, and an exponent of zero ends the run after the base reduction
// reset (rst_ni low) returns the sequencer to idle and drops valid_o
module modular_exponentiation_top #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] base_value_i,
  input  logic [63:0] exponent_i,
  input  logic [31:0] modulus_i,
  output logic        valid_o,
  output logic [31:0] power_result_o
);
  import mexp_pkg::*;

  localparam int CntW = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StDecide,
    StMul,
    StSqr
  } state_e;

  state_e               state_q;
  logic [MOD_WIDTH-1:0] pw_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [EXP_WIDTH-1:0] exp_q;
  logic [MOD_WIDTH-1:0] mod_q;
  logic [MOD_WIDTH-1:0] rem_q;
  logic [MOD_WIDTH-1:0] addend_q;
  logic [MOD_WIDTH-1:0] mult_q;
  logic [CntW-1:0]      cnt_q;
  logic                 valid_q;
  logic [31:0]          result_q;

  logic [MOD_WIDTH-1:0] rem_d;
  logic [MOD_WIDTH-1:0] mod_in;
  mexp_step_t           step;

  assign mod_in        = modulus_i[MOD_WIDTH-1:0];
  assign step.mod_zero = (mod_q == '0);
  assign step.add_en   = mult_q[MOD_WIDTH-1];

  mexp_mulstep #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_mulstep (
    .rem_i    (rem_q),
    .addend_i (addend_q),
    .modulus_i(mod_q),
    .ctrl_i   (step),
    .rem_o    (rem_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= 1'b0;
      cnt_q    <= '0;
      pw_q     <= '0;
      acc_q    <= '0;
      exp_q    <= '0;
      mod_q    <= '0;
      rem_q    <= '0;
      addend_q <= '0;
      mult_q   <= '0;
      result_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            exp_q    <= exponent_i[EXP_WIDTH-1:0];
            mod_q    <= mod_in;
            acc_q    <= MOD_WIDTH'(1);
            rem_q    <= '0;
            // base reduction as 1 * base; the addend must stay below the modulus
            addend_q <= (mod_in == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            mult_q   <= base_value_i[MOD_WIDTH-1:0];
            cnt_q    <= CntW'(MOD_WIDTH - 1);
            state_q  <= StReduce;
          end
        end
        StReduce, StMul, StSqr: begin
          rem_q  <= rem_d;
          mult_q <= {mult_q[MOD_WIDTH-2:0], 1'b0};
          cnt_q  <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            rem_q <= '0;
            cnt_q <= CntW'(MOD_WIDTH - 1);
            if (state_q == StMul) begin
              acc_q    <= rem_d;
              addend_q <= pw_q;
              mult_q   <= pw_q;
              state_q  <= StSqr;
            end else begin
              pw_q    <= rem_d;
              state_q <= StDecide;
              if (state_q == StSqr) begin
                exp_q <= exp_q >> 1;
              end
            end
          end
        end
        StDecide: begin
          rem_q    <= '0;
          cnt_q    <= CntW'(MOD_WIDTH - 1);
          addend_q <= pw_q;
          if (exp_q == '0) begin
            result_q <= 32'(acc_q);
            valid_q  <= 1'b1;
            state_q  <= StIdle;
          end else if (exp_q[0]) begin
            mult_q  <= acc_q;
            state_q <= StMul;
          end else begin
            mult_q  <= pw_q;
            state_q <= StSqr;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign valid_o        = valid_q;
  assign power_result_o = result_q;

endmodule

// ===== src/mexp_checker.sv =====
module mexp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  // a result comes only after the sequencer has gone idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("no busy after start");

  // no two strobes back to back: valid_o is never high twice in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("strobe longer than one cycle");

  // busy ends only with a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o) else $error("busy dropped without result");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .valid_o(valid_o)
);
